@@ sv/tks_pkg.sv @@
package tks_pkg;

	localparam int ID_W    = 32;
	localparam int SCORE_W = 32;
	localparam int CFG_W   = 5;
	localparam int POS_W   = 4;
	localparam int FILL_W  = 5;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_OFFER = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [CFG_W-1:0] RESULT_COUNT_RST = 5'd16;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] score;
		logic               valid;
	} slot_t;

	// per-cell command; hit_ge: some active slot at or below this one beats the
	// offered score, hit_ge_prev: same, starting one slot higher
	typedef struct packed {
		logic clear;
		logic offer;
		logic rotate;
		logic active;
		logic tail;
		logic hit_ge;
		logic hit_ge_prev;
	} cell_ctrl_t;

endpackage

@@ sv/top_k_score_selection_core.sv @@
// Channel   Handshake          Payload
// in        in_valid/in_ready  kind, candidate_id, candidate_score
// out       out_valid/out_ready slot_position, slot_id, slot_score, present,
//                              filled_count, last
// cfg       cfg_we             cfg_data (result_count)
//
// Clear and offer act on all slots at once; all slots compare and shift in parallel.
// Readout first rotates the active slot ring once around to count filled slots,
// then rotates it again to emit one slot per cycle unless the output stalls.
// in_ready is low during a readout. Async reset empties all slots, count = 16.
module top_k_score_selection_core #(
	parameter int MAX_SLOTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  kind,
	input  logic [tks_pkg::ID_W-1:0]    candidate_id,
	input  logic [tks_pkg::SCORE_W-1:0] candidate_score,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tks_pkg::POS_W-1:0]   slot_position,
	output logic [tks_pkg::ID_W-1:0]    slot_id,
	output logic [tks_pkg::SCORE_W-1:0] slot_score,
	output logic                        present,
	output logic [tks_pkg::FILL_W-1:0]  filled_count,
	output logic                        last,
	input  logic                        cfg_we,
	input  logic [tks_pkg::CFG_W-1:0]   cfg_data
);
	import tks_pkg::*;

	localparam int CNT_W = $clog2(MAX_SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_COUNT = 3'b010,
		ST_EMIT  = 3'b100
	} state_t;

	state_t             state_q;
	logic [CFG_W-1:0]   result_count_q;
	logic [CNT_W-1:0]   n_act;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   filled_q;
	logic               cnt_end;
	logic               accept;
	logic               emit_fire;
	logic               rotate;

	slot_t              cand;
	slot_t              slots [MAX_SLOTS];
	logic [MAX_SLOTS-1:0] greater;

	logic               out_valid_q;
	logic [POS_W-1:0]   slot_position_q;
	logic [ID_W-1:0]    slot_id_q;
	logic [SCORE_W-1:0] slot_score_q;
	logic               present_q;
	logic [FILL_W-1:0]  filled_count_q;
	logic               last_q;

	assign n_act = (int'(result_count_q) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS)
	                                                  : CNT_W'(result_count_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign cnt_end   = (cnt_q == CNT_W'(n_act - 1'b1));
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign rotate    = (state_q == ST_COUNT) || emit_fire;

	assign cand.id    = candidate_id;
	assign cand.score = candidate_score;
	assign cand.valid = 1'b1;

	for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_cell
		cell_ctrl_t ctrl;
		slot_t      prev_slot;
		slot_t      next_slot;

		assign ctrl.clear       = accept && (kind == KIND_CLEAR);
		assign ctrl.offer       = accept && (kind == KIND_OFFER);
		assign ctrl.rotate      = rotate;
		assign ctrl.active      = (k < int'(n_act));
		assign ctrl.tail        = (k == int'(n_act) - 1);
		assign ctrl.hit_ge      = |greater[MAX_SLOTS-1:k];

		if (k == 0) begin : g_first
			assign ctrl.hit_ge_prev = 1'b1;
			assign prev_slot        = cand;
		end else begin : g_rest
			assign ctrl.hit_ge_prev = |greater[MAX_SLOTS-1:k-1];
			assign prev_slot        = slots[k-1];
		end

		if (k == MAX_SLOTS - 1) begin : g_end
			assign next_slot = slots[0];
		end else begin : g_mid
			assign next_slot = slots[k+1];
		end

		tks_cell #(
			.INDEX(k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.cand     (cand),
			.prev_slot(prev_slot),
			.next_slot(next_slot),
			.head_slot(slots[0]),
			.slot     (slots[k]),
			.greater  (greater[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_count_q <= RESULT_COUNT_RST;
		end else if (cfg_we) begin
			result_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			filled_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q    <= '0;
					filled_q <= '0;
					if (accept && (kind == KIND_READ) && (n_act != '0)) begin
						state_q <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					filled_q <= CNT_W'(filled_q + CNT_W'(slots[0].valid));
					if (cnt_end) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= CNT_W'(cnt_q + 1'b1);
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						cnt_q <= CNT_W'(cnt_q + 1'b1);
						if (cnt_end) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			slot_position_q <= POS_W'(cnt_q);
			slot_id_q       <= slots[0].id;
			slot_score_q    <= slots[0].valid ? slots[0].score : '0;
			present_q       <= slots[0].valid;
			filled_count_q  <= FILL_W'(filled_q);
			last_q          <= cnt_end;
		end
	end

	assign out_valid     = out_valid_q;
	assign slot_position = slot_position_q;
	assign slot_id       = slot_id_q;
	assign slot_score    = slot_score_q;
	assign present       = present_q;
	assign filled_count  = filled_count_q;
	assign last          = last_q;

endmodule

@@ sv/tks_cell.sv @@
module tks_cell #(
	parameter int INDEX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tks_pkg::cell_ctrl_t ctrl,
	input  tks_pkg::slot_t     cand,
	input  tks_pkg::slot_t     prev_slot,
	input  tks_pkg::slot_t     next_slot,
	input  tks_pkg::slot_t     head_slot,
	output tks_pkg::slot_t     slot,
	output logic               greater
);
	import tks_pkg::*;

	slot_t slot_q;
	slot_t slot_d;

	assign slot    = slot_q;
	assign greater = ctrl.active && slot_q.valid && (slot_q.score > cand.score);

	always_comb begin
		slot_d = slot_q;
		if (ctrl.clear) begin
			slot_d.id    = ID_W'(INDEX);
			slot_d.score = '0;
			slot_d.valid = 1'b0;
		end else if (ctrl.offer && ctrl.active && !ctrl.hit_ge) begin
			// insertion point when this is slot 0 or the slot above holds a better score
			if (ctrl.hit_ge_prev) begin
				slot_d = cand;
			end else begin
				slot_d = prev_slot;
			end
		end else if (ctrl.rotate && ctrl.active) begin
			// readout walks the active ring toward slot 0; the tail wraps to the head
			slot_d = ctrl.tail ? head_slot : next_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q.id    <= ID_W'(INDEX);
			slot_q.score <= '0;
			slot_q.valid <= 1'b0;
		end else begin
			slot_q <= slot_d;
		end
	end

endmodule
